// ===== hw/rtl/htd_pkg.sv =====
// Package for the table-driven Huffman decoder: constants, command codes and
// the control and status structs shared by the controller and the datapath.
package htd_pkg;
	localparam int TABLE_ENTRIES_DEF = 256;
	localparam int MAX_CODE_BITS_DEF = 16;

	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic [0:0] REG_SYMBOL_COUNT = 1'b0;
	localparam logic [0:0] REG_ENTRY_COUNT = 1'b1;

	typedef struct packed {
		logic load;      // latch a new data byte
		logic tbl_wr;    // write one table entry
		logic scan_clr;  // start a table scan
		logic scan_adv;  // issue a read and advance scan index
		logic shift;     // shift one bit into accumulator
		logic acc_clr;   // clear accumulator
		logic cnt_inc;   // count a decoded symbol
		logic bit_adv;   // move to next bit of byte
		logic pend_load; // hold the new result
		logic pend_clr;  // drop the held result
	} htd_cmd_t;

	typedef struct packed {
		logic scan_end;  // scan reached entry limit
		logic hit;       // current entry matches
		logic at_limit;  // accumulator full
		logic done;      // decoded_count >= symbol_count
		logic last_bit;  // current bit is bit 0
		logic pend_vld;  // a result is held
	} htd_sts_t;
endpackage

// ===== hw/rtl/htd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module htd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hw/rtl/htd_datapath.sv =====
// Datapath: code table RAM, bit accumulator, scan index, symbol counter and
// the held result. Depends on htd_pkg and htd_ram.
module htd_datapath #(
	parameter int TABLE_ENTRIES = htd_pkg::TABLE_ENTRIES_DEF,
	parameter int MAX_CODE_BITS = htd_pkg::MAX_CODE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  htd_pkg::htd_cmd_t        cmd,
	output htd_pkg::htd_sts_t        sts,
	input  logic [7:0]               tbl_idx,
	input  logic [7:0]               tbl_symbol,
	input  logic [15:0]              tbl_code,
	input  logic [4:0]               tbl_length,
	input  logic [7:0]               data_byte,
	input  logic [23:0]              symbol_count,
	input  logic [8:0]               entry_count,
	output logic [7:0]               pend_symbol,
	output logic                     pend_ovf,
	output logic                     pend_done
);
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int LIMIT = (MAX_CODE_BITS < 16) ? MAX_CODE_BITS : 16;
	localparam int RAM_W = 8 + 16 + 5;

	logic [7:0]  byte_q;
	logic [2:0]  bit_q;
	logic [15:0] acc_q;
	logic [4:0]  len_q;
	logic [23:0] cnt_q;
	logic [8:0]  scan_q;
	logic [8:0]  limit_w;
	logic        rd_ok_q;
	logic        pend_vld_q;
	logic [7:0]  pend_symbol_q;
	logic        pend_ovf_q;
	logic        pend_done_q;
	logic [RAM_W-1:0] rdata;
	logic [15:0] mask;
	logic [4:0]  e_len;
	logic [15:0] e_code;
	logic [7:0]  e_symbol;
	logic        we_ok;
	logic        done_next;

	assign we_ok = cmd.tbl_wr && ({1'b0, tbl_idx} < 9'(TABLE_ENTRIES));
	assign limit_w = (entry_count < 9'(TABLE_ENTRIES)) ? entry_count : 9'(TABLE_ENTRIES);

	htd_ram #(.WIDTH(RAM_W), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk   (clk),
		.we    (we_ok),
		.waddr (tbl_idx[IDX_W-1:0]),
		.wdata ({tbl_symbol, tbl_code, tbl_length}),
		.re    (cmd.scan_adv),
		.raddr (scan_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	assign e_len = rdata[4:0];
	assign e_code = rdata[20:5];
	assign e_symbol = rdata[28:21];
	assign mask = (e_len >= 5'd16) ? 16'hFFFF : 16'((17'd1 << e_len) - 17'd1);

	// rd_ok_q: RAM output holds the entry read one scan step back
	assign sts.hit = rd_ok_q && e_len != 5'd0 && e_len <= 5'(LIMIT) && e_len == len_q
		&& ((e_code & mask) == acc_q);
	assign sts.scan_end = scan_q >= limit_w;
	assign sts.at_limit = len_q >= 5'(LIMIT);
	assign sts.done = cnt_q >= symbol_count;
	assign sts.last_bit = bit_q == 3'd0;
	assign sts.pend_vld = pend_vld_q;
	assign done_next = (cnt_q + 24'd1) == symbol_count;

	assign pend_symbol = pend_symbol_q;
	assign pend_ovf = pend_ovf_q;
	assign pend_done = pend_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			len_q <= '0;
			cnt_q <= '0;
			bit_q <= '0;
			scan_q <= '0;
			rd_ok_q <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				bit_q <= 3'd7;
			end else if (cmd.bit_adv) begin
				bit_q <= bit_q - 3'd1;
			end
			if (cmd.acc_clr) begin
				acc_q <= '0;
				len_q <= '0;
			end else if (cmd.shift) begin
				acc_q <= {acc_q[14:0], byte_q[bit_q]};
				len_q <= len_q + 5'd1;
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 24'd1;
			end
			if (cmd.scan_clr) begin
				scan_q <= 9'd0;
				rd_ok_q <= 1'b0;
			end else if (cmd.scan_adv) begin
				scan_q <= scan_q + 9'd1;
				rd_ok_q <= 1'b1;
			end
			if (cmd.pend_load) begin
				pend_vld_q <= 1'b1;
			end else if (cmd.pend_clr) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= data_byte;
		end
		if (cmd.pend_load) begin
			pend_symbol_q <= sts.hit ? e_symbol : 8'd0;
			pend_ovf_q <= !sts.hit;
			pend_done_q <= sts.hit && done_next;
		end
	end
endmodule

// ===== hw/rtl/htd_ctrl.sv =====
// Controller state machine for the Huffman decoder.
// Depends on htd_pkg.
module htd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_cmd,
	output logic              in_ready,
	input  logic              res_free,
	output logic              res_push,
	output logic              res_last,
	output htd_pkg::htd_cmd_t cmd,
	input  htd_pkg::htd_sts_t sts
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BIT = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0] state_q;
	logic       found_c;
	logic       take_c;

	assign in_ready = state_q == ST_IDLE;
	// a symbol match or a full accumulator with no match gives a result
	assign found_c = sts.hit || (sts.scan_end && sts.at_limit);
	// the new result can be held once the older one has moved out
	assign take_c = !sts.pend_vld || res_free;

	always_comb begin
		cmd = '0;
		res_push = 1'b0;
		res_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid && in_cmd == htd_pkg::CMD_DATA;
				cmd.tbl_wr = in_valid && in_cmd == htd_pkg::CMD_WRITE;
			end
			ST_BIT: begin
				if (!sts.done) begin
					cmd.shift = 1'b1;
					cmd.scan_clr = 1'b1;
				end
			end
			ST_SCAN: begin
				if (found_c) begin
					if (take_c) begin
						res_push = sts.pend_vld;
						cmd.pend_load = 1'b1;
						cmd.acc_clr = 1'b1;
						cmd.cnt_inc = sts.hit;
						cmd.bit_adv = !sts.last_bit;
					end
				end else if (sts.scan_end) begin
					cmd.bit_adv = !sts.last_bit;
				end else begin
					cmd.scan_adv = 1'b1;
				end
			end
			ST_FLUSH: begin
				if (sts.pend_vld && res_free) begin
					res_push = 1'b1;
					res_last = 1'b1;
					cmd.pend_clr = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (cmd.load) state_q <= ST_BIT;
				ST_BIT: state_q <= sts.done ? ST_FLUSH : ST_SCAN;
				ST_SCAN: begin
					if ((found_c && take_c) || (!found_c && sts.scan_end)) begin
						state_q <= sts.last_bit ? ST_FLUSH : ST_BIT;
					end
				end
				ST_FLUSH: if (take_c) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== hw/rtl/huffman_table_decoder_top.sv =====
// Top level of the table-driven Huffman decoder: stream ports, APB registers,
// result register. Depends on htd_pkg, htd_ctrl, htd_datapath and htd_ram.
// Each bit is shifted into the accumulator, then matched by a serial scan of up to
// L = min(entry_count, TABLE_ENTRIES) table entries; a data byte holds the input until
// its bits are processed, plus output stalls. A result waits for the next one or the byte
// end (for last). Reset: arst_n clears control and counters, not the table.
module huffman_table_decoder_top #(
	parameter int TABLE_ENTRIES = htd_pkg::TABLE_ENTRIES_DEF,
	parameter int MAX_CODE_BITS = htd_pkg::MAX_CODE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata from bit 0: entry_index[7:0], entry_symbol[7:0], entry_code[15:0],
	// entry_length[4:0], data_byte[7:0], zero pad to 48 bits
	input  logic [47:0] s_tdata,
	input  logic        s_tuser,  // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // symbol
	output logic [1:0]  m_tuser,  // overflow, done_res
	output logic        m_tlast,  // last
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [23:0] symcnt_q;
	logic [8:0]  entcnt_q;
	htd_pkg::htd_cmd_t cmd;
	htd_pkg::htd_sts_t sts;
	logic [7:0] pend_symbol;
	logic pend_ovf, pend_done, res_push, res_last, res_free;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symcnt_q <= '0;
			entcnt_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				htd_pkg::REG_SYMBOL_COUNT: symcnt_q <= pwdata[23:0];
				htd_pkg::REG_ENTRY_COUNT: entcnt_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr[2])
			htd_pkg::REG_SYMBOL_COUNT: prdata = {8'd0, symcnt_q};
			htd_pkg::REG_ENTRY_COUNT: prdata = {23'd0, entcnt_q};
			default: prdata = '0;
		endcase
	end

	// Output register frees as soon as the sink takes the held beat.
	assign res_free = !m_tvalid || m_tready;

	htd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_cmd(s_tuser),
		.in_ready(s_tready), .res_free(res_free), .res_push(res_push),
		.res_last(res_last), .cmd(cmd), .sts(sts)
	);

	htd_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_CODE_BITS(MAX_CODE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.tbl_idx(s_tdata[7:0]), .tbl_symbol(s_tdata[15:8]),
		.tbl_code(s_tdata[31:16]), .tbl_length(s_tdata[36:32]),
		.data_byte(s_tdata[44:37]), .symbol_count(symcnt_q), .entry_count(entcnt_q),
		.pend_symbol(pend_symbol), .pend_ovf(pend_ovf), .pend_done(pend_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (res_push) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end
	// Load the held result; last marks the final result of the byte
	always_ff @(posedge clk) begin
		if (res_push) begin
			m_tdata <= pend_symbol;
			m_tuser <= {pend_done, pend_ovf};
			m_tlast <= res_last;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) res_push |-> res_free)
		else $error("result pushed over held beat");
	assert property (@(posedge clk) disable iff (!arst_n) res_push |-> !s_tready)
		else $error("push while idle");
	assert property (@(posedge clk) disable iff (!arst_n) s_tready |-> !sts.pend_vld)
		else $error("idle with a held result");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast)))
		else $error("held beat changed");
endmodule

// ===== tb/sv/huffman_table_decoder_top_test.sv =====
`timescale 1ns / 1ps
// Testbench for huffman_table_decoder_top: loads code tables, streams packed
// bytes and checks every result beat against a built-in decoder model.
// Depends on htd_pkg and the decoder RTL.

class huff_scoreboard;
	// Table contents and decode state, mirrored from the block
	bit [7:0]  sym_tab [256];
	bit [15:0] code_tab [256];
	bit [4:0]  len_tab [256];
	bit [23:0] sym_target;
	bit [8:0]  entry_lim;
	bit [15:0] acc;
	bit [4:0]  acc_len;
	bit [23:0] decoded;
	bit [10:0] pending [$];  // {symbol, overflow, done, last}
	int errors;
	int results;

	function void add_expect(bit [10:0] e);
		pending.insert(pending.size(), e);
	endfunction

	function void note_input(bit cmd, bit [47:0] d);
		int n;
		int hit;
		int lim;
		bit [15:0] mask;
		if (cmd == htd_pkg::CMD_WRITE) begin
			sym_tab[d[7:0]] = d[15:8];
			code_tab[d[7:0]] = d[31:16];
			len_tab[d[7:0]] = d[36:32];
			return;
		end
		n = 0;
		lim = (entry_lim > 256) ? 256 : entry_lim;
		for (int b = 7; b >= 0; b--) begin
			if (decoded >= sym_target) break;
			acc = {acc[14:0], d[37 + b]};
			acc_len++;
			hit = -1;
			for (int i = 0; i < lim; i++) begin
				if (len_tab[i] == 0 || len_tab[i] > 16 || len_tab[i] != acc_len) continue;
				mask = (len_tab[i] >= 16) ? 16'hffff : ((16'd1 << len_tab[i]) - 16'd1);
				if ((code_tab[i] & mask) == acc) begin
					hit = i;
					break;
				end
			end
			if (hit >= 0) begin
				decoded++;
				add_expect({sym_tab[hit], 1'b0, decoded == sym_target, 1'b0});
				n++;
				acc = 0;
				acc_len = 0;
			end else if (acc_len >= 16) begin
				add_expect({8'd0, 1'b1, 1'b0, 1'b0});
				n++;
				acc = 0;
				acc_len = 0;
			end
		end
		if (n > 0) pending[$][0] = 1'b1;
	endfunction

	function void check_result(bit [7:0] sym, bit ovf, bit dn, bit lst);
		bit [10:0] e;
		results++;
		if (pending.size() == 0) begin
			$error("result beat with nothing expected");
			errors++;
			return;
		end
		e = pending.pop_front();
		if (e[10:3] != sym) begin
			$error("symbol expected %0d actual %0d", e[10:3], sym); errors++;
		end
		if (e[2] != ovf) begin
			$error("overflow expected %0d actual %0d", e[2], ovf); errors++;
		end
		if (e[1] != dn) begin
			$error("done_res expected %0d actual %0d", e[1], dn); errors++;
		end
		if (e[0] != lst) begin
			$error("last expected %0d actual %0d", e[0], lst); errors++;
		end
	endfunction
endclass

module huffman_table_decoder_top_test;
	localparam int WATCHDOG = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	huff_scoreboard sb;
	int idle_cycles;
	int bytes_sent;
	int writes_sent;
	int stall_mode;

	huffman_table_decoder_top dut (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Receiver: stall on a pattern that changes per phase, sometimes none at all
	always @(negedge clk) begin
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			default: m_tready <= ($urandom_range(0, 1) == 0);
		endcase
	end

	// Check accepted results and watch for a stuck run
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser[0], m_tuser[1], m_tlast);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || psel)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles > WATCHDOG) begin
				$display("timeout: no beat for %0d cycles", WATCHDOG);
				$display("Verification failed");
				$finish;
			end
		end
	end

	int burst_left;

	// Drop any held input beat first so it is not taken twice
	task automatic reg_write(bit [0:0] idx, bit [31:0] val);
		s_tvalid <= 0;
		burst_left = 0;
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx == htd_pkg::REG_SYMBOL_COUNT) sb.sym_target = val[23:0];
		else sb.entry_lim = val[8:0];
	endtask

	// Send one beat; the valid stays high across a burst
	task automatic send_beat(bit cmd, bit [47:0] d, bit hold);
		s_tvalid <= 1; s_tuser <= cmd; s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(cmd, d);
		if (cmd == htd_pkg::CMD_DATA) bytes_sent++; else writes_sent++;
		@(negedge clk);
		if (!hold) begin
			s_tvalid <= 0;
			s_tdata <= 48'({$urandom, $urandom});
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic send(bit cmd, bit [47:0] d);
		bit hold;
		if (burst_left <= 0) burst_left = $urandom_range(1, 8);
		burst_left--;
		hold = (burst_left != 0);
		send_beat(cmd, d, hold);
	endtask

	task automatic write_entry(bit [7:0] idx, bit [7:0] sym, bit [15:0] code, bit [4:0] len);
		bit [47:0] d;
		d = 48'({$urandom, $urandom});
		d[7:0] = idx; d[15:8] = sym; d[31:16] = code; d[36:32] = len;
		d[47:45] = 0;
		send(htd_pkg::CMD_WRITE, d);
	endtask

	task automatic send_byte(bit [7:0] b);
		bit [47:0] d;
		d = 48'({$urandom, $urandom});
		d[44:37] = b; d[47:45] = 0;
		send(htd_pkg::CMD_DATA, d);
	endtask

	// Wait until every expected result is out, then for the block's worst case
	task automatic drain();
		s_tvalid <= 0;
		burst_left = 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (8 * (256 + 3) + 20) @(negedge clk);
	endtask

	// Prefix-free table: entry i holds code i as a fixed-length code of
	// len bits with a random symbol, with entries 0..n-1 written
	task automatic load_fixed(int n, int len);
		for (int i = 0; i < n; i++)
			write_entry(8'(i), 8'($urandom), 16'((i & ((1 << len) - 1)) | ($urandom << len)),
				5'(len));
	endtask

	initial begin
		bit [7:0] b;
		int n;
		int len;
		sb = new();
		arst_n = 0; s_tvalid = 0; s_tdata = 0; s_tuser = 0; m_tready = 1;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		idle_cycles = 0; stall_mode = 0; burst_left = 0;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: with symbol_count zero nothing decodes
		load_fixed(4, 2);
		reg_write(htd_pkg::REG_ENTRY_COUNT, 4);
		send_byte(8'h1b);
		drain();

		// Directed: small variable-length table, extremes of data bytes,
		// stray high code bits, entries that never match, a 16-bit code
		reg_write(htd_pkg::REG_SYMBOL_COUNT, 24'hffffff);
		write_entry(8'd0, 8'hff, 16'hfffe, 5'd1);   // code 0, stray bits above
		write_entry(8'd1, 8'h00, 16'h0002, 5'd2);   // code 10
		write_entry(8'd2, 8'h5a, 16'h0006, 5'd3);   // code 110
		write_entry(8'd3, 8'ha5, 16'hffff, 5'd16);  // sixteen ones
		write_entry(8'd4, 8'h77, 16'h0007, 5'd0);   // zero length, never matches
		write_entry(8'd5, 8'h33, 16'h0007, 5'd31);  // too long, never matches
		reg_write(htd_pkg::REG_ENTRY_COUNT, 6);
		send_byte(8'h00);
		send_byte(8'hb6);
		send_byte(8'hff);
		send_byte(8'hff);
		send_byte(8'h00);
		drain();
		// Limit of entries searched: only entry 0 visible, then beyond table
		reg_write(htd_pkg::REG_ENTRY_COUNT, 1);
		send_byte(8'hff);   // ones never match: overflow after 16 bits
		send_byte(8'hff);
		send_byte(8'h40);
		drain();
		// Finish the pending accumulation, then stop at symbol_count
		reg_write(htd_pkg::REG_ENTRY_COUNT, 6);
		send_byte(8'h00);
		drain();
		reg_write(htd_pkg::REG_SYMBOL_COUNT, sb.decoded + 3);
		send_byte(8'h00);
		send_byte(8'h00);
		drain();

		// Random phases: decoding resumes by raising symbol_count beyond the counter (phase 6 keeps it equal)
		for (int ph = 0; ph < 8; ph++) begin
			stall_mode = ph % 3;
			n = $urandom_range(2, 16);
			len = $urandom_range(1, 4);
			if ((1 << len) < n) len = $clog2(n);
			// Codes 0..n-1 of len bits; when n < 2^len the codes missing from the
			// table give overflow
			load_fixed(n, len);
			reg_write(htd_pkg::REG_ENTRY_COUNT, n);
			reg_write(htd_pkg::REG_SYMBOL_COUNT,
				(ph == 6) ? sb.decoded : sb.decoded + $urandom_range(20, 120));
			for (int k = 0; k < 9; k++) begin
				b = 8'($urandom);
				if ($urandom_range(0, 9) == 0) begin
					// noise: rewrite a visible entry mid-stream
					write_entry(8'($urandom_range(0, n - 1)), 8'($urandom), 16'($urandom),
						5'($urandom_range(1, 16)));
				end
				send_byte(b);
			end
			drain();
		end
		// Acc state leftover: restore a clean accumulator is not needed; bits
		// keep going into whatever table is loaded.

		$display("Covered %0d data bytes and %0d table writes, %0d result beats.",
			bytes_sent, writes_sent, sb.results);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
